### src/assert_macros.svh
// Assertion macros shared by the framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/mbrf_pkg.sv
// Package with types, constants and CRC function of the request framer.
`timescale 1ns / 1ps
package mbrf_pkg;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int ADDR_W = 16;
  localparam int QTY_W = 11;
  localparam int DATA_W = 16;
  localparam int CRC_W = 16;
  localparam int ENTRY_BYTES = 7;
  localparam int NBYTES_W = 3;
  localparam int MAX_QUANTITY_DEF = 2040;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] SLAVE_ADDRESS_RST = 8'h36;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] FC_READ_INPUTS = 8'h02;
  localparam logic [BYTE_W-1:0] FC_READ_REGS = 8'h04;
  localparam logic [BYTE_W-1:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [BYTE_W-1:0] FC_WRITE_REGS = 8'h10;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ_INPUTS = 2'd0,
    KIND_READ_REGS   = 2'd1,
    KIND_WRITE_COILS = 2'd2,
    KIND_WRITE_REGS  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [ENTRY_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NBYTES_W-1:0]                nbytes;
    logic                               add_crc;
    logic                               fresh;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  function automatic logic [BYTE_W-1:0] func_code(input kind_t kind);
    logic [BYTE_W-1:0] fc;
    case (kind)
      KIND_READ_INPUTS: fc = FC_READ_INPUTS;
      KIND_READ_REGS:   fc = FC_READ_REGS;
      KIND_WRITE_COILS: fc = FC_WRITE_COILS;
      KIND_WRITE_REGS:  fc = FC_WRITE_REGS;
      default:          fc = FC_READ_INPUTS;
    endcase
    return fc;
  endfunction

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction
endpackage

### src/mbrf_req_if.sv
// Request channel carrying header and write data words.
`timescale 1ns / 1ps
interface mbrf_req_if;
  import mbrf_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [KIND_W-1:0] request_kind;
  logic [ADDR_W-1:0] start_address;
  logic [QTY_W-1:0]  quantity;
  logic [DATA_W-1:0] data_value;
  modport source (output valid, op, request_kind, start_address, quantity, data_value,
                  input ready);
  modport sink (input valid, op, request_kind, start_address, quantity, data_value,
                output ready);
endinterface

### src/mbrf_byte_if.sv
// Frame byte channel.
`timescale 1ns / 1ps
interface mbrf_byte_if;
  import mbrf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

### src/mbrf_cfg_if.sv
// Configuration write channel for the slave address register.
`timescale 1ns / 1ps
interface mbrf_cfg_if;
  import mbrf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/mbrf_front.sv
// Front end: accepts request words, tracks the open frame and queues byte groups.
`timescale 1ns / 1ps
module mbrf_front #(
  parameter int MAX_QUANTITY = mbrf_pkg::MAX_QUANTITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  mbrf_req_if.sink        req,
  mbrf_cfg_if.sink        cfg,
  input  logic            queue_full,
  output mbrf_pkg::push_t push
);
  import mbrf_pkg::*;

  logic [BYTE_W-1:0] slave_address;
  logic              frame_open, frame_open_next;
  kind_t             frame_kind, frame_kind_next;
  logic [QTY_W-1:0]  elements_left, elements_left_next;
  logic [BYTE_W-1:0] coil_byte, coil_byte_next;
  logic [2:0]        coil_pos, coil_pos_next;

  kind_t             kind;
  logic [QTY_W-1:0]  qty;
  logic [QTY_W:0]    coil_sum;
  logic [BYTE_W-1:0] payload_len;
  logic [QTY_W-1:0]  left_dec;
  logic [BYTE_W-1:0] coil_merged;
  logic [2:0]        pos_inc;
  logic              is_write;

  assign req.ready = !queue_full;
  assign cfg.ready = 1'b1;

  assign kind = kind_t'(req.request_kind);
  assign qty = (req.quantity > QTY_W'(MAX_QUANTITY)) ? QTY_W'(MAX_QUANTITY) : req.quantity;
  assign coil_sum = {1'b0, qty} + (QTY_W+1)'(7);
  assign payload_len = (kind == KIND_WRITE_COILS) ? coil_sum[BYTE_W+2:3] : {qty[6:0], 1'b0};
  assign is_write = (kind == KIND_WRITE_COILS) || (kind == KIND_WRITE_REGS);
  assign left_dec = elements_left - QTY_W'(1);
  assign coil_merged = coil_byte | ((req.data_value != '0) ? (BYTE_W'(1) << coil_pos) : '0);
  assign pos_inc = coil_pos + 3'd1;

  always_comb begin
    push = '0;
    frame_open_next = frame_open;
    frame_kind_next = frame_kind;
    elements_left_next = elements_left;
    coil_byte_next = coil_byte;
    coil_pos_next = coil_pos;
    if (req.valid && req.ready) begin
      if (op_t'(req.op) == OP_HEADER) begin
        push.push = 1'b1;
        push.entry.fresh = 1'b1;
        push.entry.bytes[0] = slave_address;
        push.entry.bytes[1] = func_code(kind);
        push.entry.bytes[2] = req.start_address[15:8];
        push.entry.bytes[3] = req.start_address[7:0];
        push.entry.bytes[4] = {5'd0, qty[10:8]};
        push.entry.bytes[5] = qty[7:0];
        push.entry.bytes[6] = payload_len;
        push.entry.nbytes = is_write ? NBYTES_W'(7) : NBYTES_W'(6);
        push.entry.add_crc = !is_write || (qty == '0);
        frame_kind_next = kind;
        frame_open_next = is_write && (qty != '0);
        elements_left_next = (is_write && (qty != '0)) ? qty : '0;
        coil_byte_next = '0;
        coil_pos_next = '0;
      end else if (frame_open && (elements_left != '0)) begin
        elements_left_next = left_dec;
        push.entry.add_crc = (left_dec == '0);
        if (frame_kind == KIND_WRITE_COILS) begin
          if ((pos_inc == 3'd0) || (left_dec == '0)) begin
            push.entry.bytes[0] = coil_merged;
            push.entry.nbytes = NBYTES_W'(1);
            coil_byte_next = '0;
            coil_pos_next = '0;
          end else begin
            coil_byte_next = coil_merged;
            coil_pos_next = pos_inc;
          end
        end else begin
          push.entry.bytes[0] = req.data_value[15:8];
          push.entry.bytes[1] = req.data_value[7:0];
          push.entry.nbytes = NBYTES_W'(2);
        end
        push.push = (push.entry.nbytes != '0) || push.entry.add_crc;
        if (left_dec == '0) begin
          frame_open_next = 1'b0;
          coil_byte_next = '0;
          coil_pos_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RST;
      frame_open <= 1'b0;
      frame_kind <= KIND_READ_INPUTS;
      elements_left <= '0;
      coil_byte <= '0;
      coil_pos <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        slave_address <= cfg.data;
      end
      frame_open <= frame_open_next;
      frame_kind <= frame_kind_next;
      elements_left <= elements_left_next;
      coil_byte <= coil_byte_next;
      coil_pos <= coil_pos_next;
    end
  end
endmodule

### src/mbrf_queue.sv
// Short queue of byte groups between the front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbrf_queue #(
  parameter int QUEUE_DEPTH = mbrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  mbrf_pkg::push_t  push,
  output logic             full,
  output logic             head_valid,
  output mbrf_pkg::entry_t head,
  input  logic             pop
);
  import mbrf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];
  assign do_push = push.push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_RST(a_no_push_when_full, clk, rst, !(push.push && full), "push into full queue")
  `ASSERT_RST(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
endmodule

### src/mbrf_back.sv
// Back end: serializes queued byte groups, runs the CRC and appends it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbrf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  mbrf_pkg::entry_t head,
  output logic             pop,
  mbrf_byte_if.source      frame
);
  import mbrf_pkg::*;

  typedef enum logic [2:0] {
    ST_DATA   = 3'b001,
    ST_CRC_LO = 3'b010,
    ST_CRC_HI = 3'b100
  } back_state_t;

  back_state_t         state, state_next;
  logic [NBYTES_W-1:0] idx, idx_next;
  logic [CRC_W-1:0]    crc, crc_next;
  logic [CRC_W-1:0]    crc_base;
  logic                advance;
  logic [BYTE_W-1:0]   byte_next;
  logic                last_next;

  assign advance = head_valid && (!frame.valid || frame.ready);
  assign crc_base = (head.fresh && (idx == '0)) ? CRC_INIT : crc;

  always_comb begin
    state_next = state;
    idx_next = idx;
    crc_next = crc;
    byte_next = head.bytes[idx];
    last_next = 1'b0;
    pop = 1'b0;
    if (advance) begin
      case (state)
        ST_DATA: begin
          crc_next = crc_update(crc_base, head.bytes[idx]);
          if (idx == head.nbytes - NBYTES_W'(1)) begin
            idx_next = '0;
            if (head.add_crc) begin
              state_next = ST_CRC_LO;
            end else begin
              pop = 1'b1;
            end
          end else begin
            idx_next = idx + NBYTES_W'(1);
          end
        end
        ST_CRC_LO: begin
          byte_next = crc[7:0];
          state_next = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          byte_next = crc[15:8];
          last_next = 1'b1;
          crc_next = CRC_INIT;
          state_next = ST_DATA;
          pop = 1'b1;
        end
        default: begin
          state_next = ST_DATA;
          idx_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DATA;
      idx <= '0;
      crc <= CRC_INIT;
      frame.valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      crc <= crc_next;
      if (advance) begin
        frame.valid <= 1'b1;
      end else if (frame.ready) begin
        frame.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame.frame_byte <= byte_next;
      frame.last_byte <= last_next;
    end
  end

  `ASSERT_RST(a_group_not_empty, clk, rst, head_valid |-> (head.nbytes != '0),
              "empty byte group at queue head")
  `ASSERT_RST(a_crc_cleared, clk, rst,
              (advance && (state == ST_CRC_HI)) |=> (crc == CRC_INIT),
              "CRC not reinitialized after frame end")
endmodule

### src/modbus_rtu_request_framer.sv
// Top level of the Modbus RTU request framer.
`timescale 1ns / 1ps
// The req channel takes words: op 0 is a header (request_kind, start_address,
// quantity), op 1 is one write data element in data_value. Data words while
// no write frame is open are dropped. The frame channel returns the frame one
// byte per word, with last_byte set on the high CRC byte. The cfg channel sets
// the slave address; it is always ready and should be written only while idle.
// A header word yields 6 or 7 bytes plus 2 CRC bytes for reads or empty
// writes, a register word 2 bytes, a coil word a byte every eighth word and
// on the last one; the last data word adds the 2 CRC bytes. The back end
// emits one byte per cycle while the receiver is ready, and each byte passes
// the byte group queue and then the output register. The front end takes one
// word per cycle until the byte group queue is full. A stalled receiver holds
// the output register, the back end then stops, and req.ready falls once the
// queue fills. Reset clears the queue, the open frame and the CRC, and sets the slave address to 0x36.
module modbus_rtu_request_framer #(
  parameter int MAX_QUANTITY = mbrf_pkg::MAX_QUANTITY_DEF,
  parameter int QUEUE_DEPTH = mbrf_pkg::QUEUE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  mbrf_req_if.sink    req,
  mbrf_cfg_if.sink    cfg,
  mbrf_byte_if.source frame
);
  import mbrf_pkg::*;

  push_t  push;
  logic   queue_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  mbrf_front #(
    .MAX_QUANTITY(MAX_QUANTITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .queue_full(queue_full),
    .push      (push)
  );

  mbrf_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  mbrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .frame     (frame)
  );
endmodule
